[rtl/core/hcbd_pkg.sv]
// ----------------------------------------------------------------------------
// hcbd_pkg
// Types, constants and helper functions for the chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

    // Width of the chunk size counter
    localparam int SIZE_BITS = 32;

    // Result kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Characters of interest
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_X_LC  = 8'h78;
    localparam logic [7:0] CH_X_UC  = 8'h58;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_LC  = 8'h61;
    localparam logic [7:0] CH_F_LC  = 8'h66;
    localparam logic [7:0] CH_A_UC  = 8'h41;
    localparam logic [7:0] CH_F_UC  = 8'h46;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_DONE     = 6'b000001,
        PH_SIZE     = 6'b000010,
        PH_SIZE_BAD = 6'b000100,
        PH_DATA     = 6'b001000,
        PH_SKIP1    = 6'b010000,
        PH_SKIP2    = 6'b100000
    } phase_t;

    // Decoded hex digit
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    // Size line parse state
    typedef struct packed {
        logic                 bad;
        logic [SIZE_BITS-1:0] accum;
        logic                 seen;
        logic                 ended;
        logic                 pzero;
    } size_st_t;

    function automatic hex_t hex_decode(logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= CH_0 && c <= CH_9)
            h.value = 4'(c - CH_0);
        else if (c >= CH_A_LC && c <= CH_F_LC)
            h.value = 4'(c - CH_A_LC + 8'd10);
        else if (c >= CH_A_UC && c <= CH_F_UC)
            h.value = 4'(c - CH_A_UC + 8'd10);
        else
            h.valid = 1'b0;
        return h;
    endfunction

    // One byte of size line text (not part of the CR LF terminator)
    function automatic size_st_t size_text(size_st_t s, logic [7:0] c);
        size_st_t r;
        hex_t     h;
        logic     ws;
        r  = s;
        h  = hex_decode(c);
        ws = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
        if (!s.bad && !s.ended)
        begin
            if (h.valid)
            begin
                // a shift that would drop set bits marks the line oversized
                if (|s.accum[SIZE_BITS-1 -: 4])
                    r.bad = 1'b1;
                else
                begin
                    r.pzero = !s.seen && (h.value == 4'd0);
                    r.accum = {s.accum[SIZE_BITS-5:0], h.value};
                    r.seen  = 1'b1;
                end
            end
            else if ((c == CH_X_LC || c == CH_X_UC) && s.pzero)
                r.pzero = 1'b0;
            else if (!s.seen && ws)
                r = s;
            else
                r.ended = 1'b1;
        end
        return r;
    endfunction

endpackage

[rtl/core/http_chunked_body_decoder.sv]
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Parses a chunked body byte stream and passes on only the payload bytes,
// plus one end-of-body or error result per size line that finishes the body.
// ----------------------------------------------------------------------------
// Path: input register, then result register. Throughput: one byte per
// cycle unless m_tready stalls the result register; the parse of a byte is
// a single hex shift-add and state update between the two registers.
// Reset: asynchronous, active low; parser waits for a byte marked body start,
// both register stages empty.
module http_chunked_body_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] body_start
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser    // [1:0] out_kind
);

    localparam int SB = hcbd_pkg::SIZE_BITS;

    // Input stage
    logic       in_vld_reg;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;

    // Parser state
    hcbd_pkg::phase_t phase_reg, phase_next;
    hcbd_pkg::size_st_t sz_reg, sz_next;
    logic [SB-1:0] left_reg, left_next;
    logic          cr_reg, cr_next;

    // Result stage
    logic       out_vld_reg;
    logic [7:0] out_byte_reg;
    logic [1:0] out_kind_reg;

    logic       advance;
    logic       res_vld;
    logic [7:0] res_byte;
    logic [1:0] res_kind;

    hcbd_pkg::phase_t   ph_eff;
    hcbd_pkg::size_st_t sz_eff;
    hcbd_pkg::size_st_t sz_mid;
    logic               cr_eff;

    // Pipeline moves when the result slot is free or being drained
    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_kind_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (s_tready)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    // Per-byte parse
    always_comb
    begin
        // body start restarts the size line
        ph_eff = phase_reg;
        sz_eff = sz_reg;
        cr_eff = cr_reg;
        if (in_start_reg)
        begin
            ph_eff = hcbd_pkg::PH_SIZE;
            sz_eff = '0;
            cr_eff = 1'b0;
        end

        phase_next = ph_eff;
        sz_next    = sz_eff;
        cr_next    = cr_eff;
        left_next  = left_reg;
        res_vld    = 1'b0;
        res_byte   = 8'd0;
        res_kind   = hcbd_pkg::KIND_DATA;
        sz_mid     = sz_eff;

        unique case (ph_eff)
            hcbd_pkg::PH_SIZE, hcbd_pkg::PH_SIZE_BAD:
            begin
                if (cr_eff && in_byte_reg == hcbd_pkg::CH_LF)
                begin
                    cr_next = 1'b0;
                    if (sz_eff.bad || !sz_eff.seen)
                    begin
                        phase_next = hcbd_pkg::PH_DONE;
                        res_vld    = 1'b1;
                        res_kind   = hcbd_pkg::KIND_ERR;
                    end
                    else if (sz_eff.accum == '0)
                    begin
                        phase_next = hcbd_pkg::PH_DONE;
                        res_vld    = 1'b1;
                        res_kind   = hcbd_pkg::KIND_END;
                    end
                    else
                    begin
                        left_next  = sz_eff.accum;
                        phase_next = hcbd_pkg::PH_DATA;
                    end
                end
                else
                begin
                    // a held CR not followed by LF is plain line text
                    if (cr_eff)
                        sz_mid = hcbd_pkg::size_text(sz_eff, hcbd_pkg::CH_CR);
                    cr_next = (in_byte_reg == hcbd_pkg::CH_CR);
                    if (!cr_next)
                        sz_next = hcbd_pkg::size_text(sz_mid, in_byte_reg);
                    else
                        sz_next = sz_mid;
                    phase_next = sz_next.bad ? hcbd_pkg::PH_SIZE_BAD : hcbd_pkg::PH_SIZE;
                end
            end
            hcbd_pkg::PH_DATA:
            begin
                if (left_reg != '0)
                    left_next = left_reg - SB'(1);
                if (left_reg <= SB'(1))
                    phase_next = hcbd_pkg::PH_SKIP1;
                res_vld  = 1'b1;
                res_byte = in_byte_reg;
                res_kind = hcbd_pkg::KIND_DATA;
            end
            hcbd_pkg::PH_SKIP1:
                phase_next = hcbd_pkg::PH_SKIP2;
            hcbd_pkg::PH_SKIP2:
            begin
                phase_next = hcbd_pkg::PH_SIZE;
                sz_next    = '0;
                cr_next    = 1'b0;
            end
            default:
                phase_next = hcbd_pkg::PH_DONE;
        endcase
    end

    // Parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hcbd_pkg::PH_DONE;
            sz_reg    <= '0;
            left_reg  <= '0;
            cr_reg    <= 1'b0;
        end
        else if (in_vld_reg && advance)
        begin
            phase_reg <= phase_next;
            sz_reg    <= sz_next;
            left_reg  <= left_next;
            cr_reg    <= cr_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= in_vld_reg && res_vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_vld_reg && res_vld)
        begin
            out_byte_reg <= res_byte;
            out_kind_reg <= res_kind;
        end
    end

    // Checks
    a_ctrl_zero_byte : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != hcbd_pkg::KIND_DATA |-> m_tdata == 8'd0)
        else $error("end or error result carries a nonzero byte");

    a_data_count : assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == hcbd_pkg::PH_DATA |-> left_reg != '0)
        else $error("data phase with no bytes left");

    a_end_to_done : assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && advance && res_vld && res_kind != hcbd_pkg::KIND_DATA
        |=> phase_reg == hcbd_pkg::PH_DONE)
        else $error("parser not done after end or error");

endmodule
